/* rtl/prc_pkg.sv */
package prc_pkg;

   // default coordinate width and register reset values
   localparam int COORD_WIDTH_DEF = 16;
   localparam int X_LOW_RST       = 200;
   localparam int Y_LOW_RST       = 200;
   localparam int X_HIGH_RST      = 400;
   localparam int Y_HIGH_RST      = 400;

   // config register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_X_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Y_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X_HIGH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_HIGH = 2'd3;

   // input queue and work stack sizes
   localparam int QUEUE_DEPTH = 4;
   localparam int STACK_DEPTH = 16;

   // clip stages; stage SINK is the output end of the chain
   localparam int NUM_STAGES = 4;
   localparam logic [2:0] STG_LEFT   = 3'd0;
   localparam logic [2:0] STG_RIGHT  = 3'd1;
   localparam logic [2:0] STG_BOTTOM = 3'd2;
   localparam logic [2:0] STG_TOP    = 3'd3;
   localparam logic [2:0] STG_SINK   = 3'd4;

   typedef enum logic [1:0] {
      EDGE_OUT_IN,
      EDGE_IN_IN,
      EDGE_IN_OUT,
      EDGE_OUT_OUT
   } edge_code_type;

endpackage

/* rtl/prc_front.sv */
module prc_front #(
   parameter int CW = prc_pkg::COORD_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [CW-1:0] req_in_x,
   input  logic [CW-1:0] req_in_y,
   input  logic          req_in_last,
   output logic          q_valid,
   output logic [CW-1:0] q_x,
   output logic [CW-1:0] q_y,
   output logic          q_last,
   input  logic          q_pop
);

   localparam int QD  = prc_pkg::QUEUE_DEPTH;
   localparam int QAW = $clog2(QD);

   logic [CW-1:0]  qx_ff [QD];
   logic [CW-1:0]  qy_ff [QD];
   logic           ql_ff [QD];
   logic [QAW-1:0] wp_ff, rp_ff;
   logic [QAW:0]   cnt_ff;
   logic           push, pop;

   assign req_stall = (cnt_ff == (QAW+1)'(QD));
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && q_valid;
   assign q_valid   = (cnt_ff != '0);
   assign q_x       = qx_ff[rp_ff];
   assign q_y       = qy_ff[rp_ff];
   assign q_last    = ql_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         qx_ff[wp_ff] <= req_in_x;
         qy_ff[wp_ff] <= req_in_y;
         ql_ff[wp_ff] <= req_in_last;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + QAW'(1);
         if (pop)  rp_ff <= rp_ff + QAW'(1);
         if (push && !pop)      cnt_ff <= cnt_ff + (QAW+1)'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - (QAW+1)'(1);
      end
   end

endmodule

/* rtl/prc_back.sv */
module prc_back #(
   parameter int CW = prc_pkg::COORD_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [CW-1:0] x_low,
   input  logic [CW-1:0] y_low,
   input  logic [CW-1:0] x_high,
   input  logic [CW-1:0] y_high,
   input  logic          q_valid,
   input  logic [CW-1:0] q_x,
   input  logic [CW-1:0] q_y,
   input  logic          q_last,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [CW-1:0] rsp_out_x,
   output logic [CW-1:0] rsp_out_y,
   output logic          rsp_out_last,
   output logic          rsp_out_empty
);

   localparam int SD   = prc_pkg::STACK_DEPTH;
   localparam int SPW  = $clog2(SD);
   localparam int NS   = prc_pkg::NUM_STAGES;
   localparam int PW   = 2 * CW + 2;
   localparam int CNTW = $clog2(PW);

   typedef enum logic [2:0] {
      S_LOAD, S_EVAL, S_EDGE, S_MUL, S_DIV, S_DONE
   } state_type;

   state_type       state_ff;
   logic [SPW-1:0]  sp_ff;
   logic            st_end_ff [SD];
   logic [2:0]      st_stg_ff [SD];
   logic [CW-1:0]   st_x_ff   [SD];
   logic [CW-1:0]   st_y_ff   [SD];

   logic            cur_end_ff;
   logic [2:0]      cur_stg_ff;
   logic [CW-1:0]   cur_x_ff, cur_y_ff, ex1_ff, ey1_ff;

   logic [CW-1:0]   first_x_ff [NS];
   logic [CW-1:0]   first_y_ff [NS];
   logic [CW-1:0]   prev_x_ff  [NS];
   logic [CW-1:0]   prev_y_ff  [NS];
   logic            hf_ff      [NS];

   logic [CW-1:0]   pend_x_ff, pend_y_ff;
   logic            pend_v_ff;

   logic [CW:0]     magd_ff, mage_ff, magf_ff;
   logic [PW-1:0]   prod_ff;
   logic [CW+1:0]   rem_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            neg_ff, vert_ff;
   logic [CW-1:0]   base_ff, bnd_ff;

   logic            out_v_ff, out_last_ff, out_empty_ff;
   logic [CW-1:0]   out_x_ff, out_y_ff;

   // edge classification and set-up
   logic [1:0]         k;
   logic               vert, high;
   logic signed [CW-1:0] b, p1, p2, b1, b2;
   logic signed [CW:0] d, e, f;
   logic               g1, g2, o1, o2, eq1, eq2;
   prc_pkg::edge_code_type code;
   logic               out_free;
   logic               out_load;
   logic [CW+1:0]      rem_sh;
   logic [CW+1:0]      res;
   logic [SPW-1:0]     top;

   assign k        = cur_stg_ff[1:0];
   assign out_free = !out_v_ff || !rsp_stall;
   assign top      = sp_ff - SPW'(1);
   assign q_pop    = (state_ff == S_LOAD) && (sp_ff == '0) && q_valid;
   // sink hands a word to the output register this cycle
   assign out_load = (state_ff == S_EVAL) && (cur_stg_ff == prc_pkg::STG_SINK) && out_free
                     && (cur_end_ff || pend_v_ff);

   always_comb begin
      vert = (cur_stg_ff == prc_pkg::STG_LEFT) || (cur_stg_ff == prc_pkg::STG_RIGHT);
      high = (cur_stg_ff == prc_pkg::STG_RIGHT) || (cur_stg_ff == prc_pkg::STG_BOTTOM);
      case (cur_stg_ff)
         prc_pkg::STG_LEFT:   b = x_low;
         prc_pkg::STG_RIGHT:  b = x_high;
         prc_pkg::STG_BOTTOM: b = y_high;
         default:             b = y_low;
      endcase
      p1  = vert ? ex1_ff   : ey1_ff;
      p2  = vert ? cur_x_ff : cur_y_ff;
      b1  = vert ? ey1_ff   : ex1_ff;
      b2  = vert ? cur_y_ff : cur_x_ff;
      d   = (CW+1)'(b2) - (CW+1)'(b1);
      e   = (CW+1)'(b)  - (CW+1)'(p1);
      f   = (CW+1)'(p2) - (CW+1)'(p1);
      eq1 = (p1 == b);
      eq2 = (p2 == b);
      g1  = high ? (p1 < b) : (p1 > b);
      g2  = high ? (p2 < b) : (p2 > b);
      o1  = !g1 && !eq1;
      o2  = !g2 && !eq2;
      if (eq1 && eq2)      code = prc_pkg::EDGE_IN_IN;
      else if (!g1 && !g2) code = prc_pkg::EDGE_OUT_OUT;
      else if (o1 && g2)   code = prc_pkg::EDGE_OUT_IN;
      else if (g1 && o2)   code = prc_pkg::EDGE_IN_OUT;
      else                 code = prc_pkg::EDGE_IN_IN;
      rem_sh = {rem_ff[CW:0], prod_ff[PW-1]};
      res    = neg_ff ? ((CW+2)'(signed'(base_ff)) - prod_ff[CW+1:0])
                      : ((CW+2)'(signed'(base_ff)) + prod_ff[CW+1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_LOAD;
         sp_ff     <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         for (int i = 0; i < NS; i++) begin
            hf_ff[i] <= 1'b0;
         end
      end else begin
         if (out_load)        out_v_ff <= 1'b1;
         else if (!rsp_stall) out_v_ff <= 1'b0;
         case (state_ff)
            S_LOAD: begin
               if (sp_ff != '0) begin
                  cur_end_ff <= st_end_ff[top];
                  cur_stg_ff <= st_stg_ff[top];
                  cur_x_ff   <= st_x_ff[top];
                  cur_y_ff   <= st_y_ff[top];
                  sp_ff      <= top;
                  state_ff   <= S_EVAL;
               end else if (q_valid) begin
                  cur_end_ff <= 1'b0;
                  cur_stg_ff <= prc_pkg::STG_LEFT;
                  cur_x_ff   <= q_x;
                  cur_y_ff   <= q_y;
                  if (q_last) begin
                     st_end_ff[sp_ff] <= 1'b1;
                     st_stg_ff[sp_ff] <= prc_pkg::STG_LEFT;
                     sp_ff            <= sp_ff + SPW'(1);
                  end
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               if (cur_stg_ff == prc_pkg::STG_SINK) begin
                  if (cur_end_ff) begin
                     if (out_free) begin
                        out_x_ff     <= pend_v_ff ? pend_x_ff : '0;
                        out_y_ff     <= pend_v_ff ? pend_y_ff : '0;
                        out_last_ff  <= 1'b1;
                        out_empty_ff <= !pend_v_ff;
                        pend_v_ff    <= 1'b0;
                        state_ff     <= S_LOAD;
                     end
                  end else if (!pend_v_ff || out_free) begin
                     if (pend_v_ff) begin
                        out_x_ff     <= pend_x_ff;
                        out_y_ff     <= pend_y_ff;
                        out_last_ff  <= 1'b0;
                        out_empty_ff <= 1'b0;
                     end
                     pend_x_ff <= cur_x_ff;
                     pend_y_ff <= cur_y_ff;
                     pend_v_ff <= 1'b1;
                     state_ff  <= S_LOAD;
                  end
               end else if (cur_end_ff) begin
                  st_end_ff[sp_ff] <= 1'b1;
                  st_stg_ff[sp_ff] <= cur_stg_ff + 3'd1;
                  sp_ff            <= sp_ff + SPW'(1);
                  hf_ff[k]         <= 1'b0;
                  if (hf_ff[k]) begin
                     ex1_ff   <= prev_x_ff[k];
                     ey1_ff   <= prev_y_ff[k];
                     cur_x_ff <= first_x_ff[k];
                     cur_y_ff <= first_y_ff[k];
                     state_ff <= S_EDGE;
                  end else begin
                     state_ff <= S_LOAD;
                  end
               end else if (!hf_ff[k]) begin
                  first_x_ff[k] <= cur_x_ff;
                  first_y_ff[k] <= cur_y_ff;
                  prev_x_ff[k]  <= cur_x_ff;
                  prev_y_ff[k]  <= cur_y_ff;
                  hf_ff[k]      <= 1'b1;
                  state_ff      <= S_LOAD;
               end else begin
                  ex1_ff       <= prev_x_ff[k];
                  ey1_ff       <= prev_y_ff[k];
                  prev_x_ff[k] <= cur_x_ff;
                  prev_y_ff[k] <= cur_y_ff;
                  state_ff     <= S_EDGE;
               end
            end
            S_EDGE: begin
               // end point goes on the stack first so the crossing is handled before it
               if (code == prc_pkg::EDGE_IN_IN || code == prc_pkg::EDGE_OUT_IN) begin
                  st_end_ff[sp_ff] <= 1'b0;
                  st_stg_ff[sp_ff] <= cur_stg_ff + 3'd1;
                  st_x_ff[sp_ff]   <= cur_x_ff;
                  st_y_ff[sp_ff]   <= cur_y_ff;
                  sp_ff            <= sp_ff + SPW'(1);
               end
               if (code == prc_pkg::EDGE_IN_OUT || code == prc_pkg::EDGE_OUT_IN) begin
                  magd_ff  <= d[CW] ? -d : d;
                  mage_ff  <= e[CW] ? -e : e;
                  magf_ff  <= f[CW] ? -f : f;
                  neg_ff   <= (d[CW] ^ e[CW]) ^ f[CW];
                  base_ff  <= b1;
                  bnd_ff   <= b;
                  vert_ff  <= vert;
                  state_ff <= S_MUL;
               end else begin
                  state_ff <= S_LOAD;
               end
            end
            S_MUL: begin
               prod_ff  <= PW'(magd_ff) * PW'(mage_ff);
               rem_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               // restoring divide, one quotient bit a cycle
               if (rem_sh >= (CW+2)'(magf_ff)) begin
                  rem_ff  <= rem_sh - (CW+2)'(magf_ff);
                  prod_ff <= {prod_ff[PW-2:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  prod_ff <= {prod_ff[PW-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + CNTW'(1);
               if (cnt_ff == CNTW'(PW-1)) state_ff <= S_DONE;
            end
            S_DONE: begin
               st_end_ff[sp_ff] <= 1'b0;
               st_stg_ff[sp_ff] <= cur_stg_ff + 3'd1;
               st_x_ff[sp_ff]   <= vert_ff ? bnd_ff : res[CW-1:0];
               st_y_ff[sp_ff]   <= vert_ff ? res[CW-1:0] : bnd_ff;
               sp_ff            <= sp_ff + SPW'(1);
               state_ff         <= S_LOAD;
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_out_last  = out_last_ff;
   assign rsp_out_empty = out_empty_ff;

endmodule

/* rtl/polygon_rect_clipper_top.sv */
// channel | direction | handshake             | word
// req_    | in        | req_valid / req_stall | in_x, in_y, in_last
// rsp_    | out       | rsp_valid / rsp_stall | out_x, out_y, out_last, out_empty
// csr_    | in        | csr_valid / csr_ready | csr_index, csr_data
//
// Work: an edge that crosses a boundary goes through the shared multiply and
// the one-bit-a-cycle restoring divider. Up to four input words queue ahead.
// Reset: synchronous, clears queue, work stack, stage state and output register;
// boundaries return to 200/400. csr_ready is always high.
// Stalls: rsp_stall holds only the output register; the back end waits when it
// has a word to hand over and the register is still full.
module polygon_rect_clipper_top #(
   parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [COORD_WIDTH-1:0]          req_in_x,
   input  logic [COORD_WIDTH-1:0]          req_in_y,
   input  logic                            req_in_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [COORD_WIDTH-1:0]          rsp_out_x,
   output logic [COORD_WIDTH-1:0]          rsp_out_y,
   output logic                            rsp_out_last,
   output logic                            rsp_out_empty,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [prc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [COORD_WIDTH-1:0]          csr_data
);

   logic [COORD_WIDTH-1:0] x_low_ff, y_low_ff, x_high_ff, y_high_ff;
   logic                   q_valid, q_last, q_pop;
   logic [COORD_WIDTH-1:0] q_x, q_y;

   assign csr_ready = 1'b1;

   // boundary registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff  <= COORD_WIDTH'(prc_pkg::X_LOW_RST);
         y_low_ff  <= COORD_WIDTH'(prc_pkg::Y_LOW_RST);
         x_high_ff <= COORD_WIDTH'(prc_pkg::X_HIGH_RST);
         y_high_ff <= COORD_WIDTH'(prc_pkg::Y_HIGH_RST);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            prc_pkg::REG_X_LOW:  x_low_ff  <= csr_data;
            prc_pkg::REG_Y_LOW:  y_low_ff  <= csr_data;
            prc_pkg::REG_X_HIGH: x_high_ff <= csr_data;
            prc_pkg::REG_Y_HIGH: y_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // front: input queue
   prc_front #(.CW(COORD_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_x    (req_in_x),
      .req_in_y    (req_in_y),
      .req_in_last (req_in_last),
      .q_valid     (q_valid),
      .q_x         (q_x),
      .q_y         (q_y),
      .q_last      (q_last),
      .q_pop       (q_pop)
   );

   // back: four clip stages run by one sequencer over a work stack
   prc_back #(.CW(COORD_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .x_low         (x_low_ff),
      .y_low         (y_low_ff),
      .x_high        (x_high_ff),
      .y_high        (y_high_ff),
      .q_valid       (q_valid),
      .q_x           (q_x),
      .q_y           (q_y),
      .q_last        (q_last),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_last  (rsp_out_last),
      .rsp_out_empty (rsp_out_empty)
   );

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam int CW        = 16;
   localparam int CYC_LIMIT = 2000000;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic          last;
      logic          empty;
   } clip_word_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   logic [CW-1:0] req_in_x;
   logic [CW-1:0] req_in_y;
   logic          req_in_last;
   logic          rsp_valid;
   logic          rsp_stall;
   logic [CW-1:0] rsp_out_x;
   logic [CW-1:0] rsp_out_y;
   logic          rsp_out_last;
   logic          rsp_out_empty;
   logic          csr_valid;
   logic          csr_ready;
   logic [prc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [CW-1:0] csr_data;

   // idling percentages, changed per phase
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned n_fail = 0;
   int unsigned n_cycles = 0;

   clip_word_type expected_words[$];

   // predictor state: boundaries and per-stage first/previous vertex
   longint bnd_x_low, bnd_y_low, bnd_x_high, bnd_y_high;
   longint stg_first_x[4], stg_first_y[4], stg_prev_x[4], stg_prev_y[4];
   bit     stg_open[4];
   longint hold_x, hold_y;
   bit     hold_valid;

   polygon_rect_clipper_top #(.COORD_WIDTH(CW)) uut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles > CYC_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint lerp_coord(longint a1, longint b1, longint a2, longint b2,
                                         longint pos);
      longint d, e, f, q;
      d = b2 - b1;
      e = pos - a1;
      f = a2 - a1;
      if (f == 0) return b1;
      q = ((d < 0 ? -d : d) * (e < 0 ? -e : e)) / (f < 0 ? -f : f);
      return (((d < 0) != (e < 0)) != (f < 0)) ? b1 - q : b1 + q;
   endfunction

   function automatic prc_pkg::edge_code_type edge_kind(longint p1, longint p2, longint b);
      if (p1 == b && p2 == b) return prc_pkg::EDGE_IN_IN;
      if (p1 <= b && p2 <= b) return prc_pkg::EDGE_OUT_OUT;
      if (p1 < b && p2 > b)   return prc_pkg::EDGE_OUT_IN;
      if (p1 > b && p2 < b)   return prc_pkg::EDGE_IN_OUT;
      return prc_pkg::EDGE_IN_IN;
   endfunction

   function automatic void push_word(longint x, longint y, bit last, bit empty);
      clip_word_type w;
      w.x = x[CW-1:0];
      w.y = y[CW-1:0];
      w.last = last;
      w.empty = empty;
      expected_words.push_back(w);
   endfunction

   // recursive descent through the stage chain; stage 4 is the output hold
   function automatic void feed_stage(int k, longint x, longint y);
      longint x1, y1;
      if (k >= 4) begin
         if (hold_valid) push_word(hold_x, hold_y, 1'b0, 1'b0);
         hold_x = x;
         hold_y = y;
         hold_valid = 1'b1;
         return;
      end
      if (!stg_open[k]) begin
         stg_first_x[k] = x; stg_first_y[k] = y;
         stg_prev_x[k]  = x; stg_prev_y[k]  = y;
         stg_open[k] = 1'b1;
         return;
      end
      x1 = stg_prev_x[k];
      y1 = stg_prev_y[k];
      stg_prev_x[k] = x;
      stg_prev_y[k] = y;
      clip_edge_k(k, x1, y1, x, y);
   endfunction

   function automatic void clip_edge_k(int k, longint x1, longint y1, longint x2, longint y2);
      bit vert, hi;
      longint b, p1, p2;
      prc_pkg::edge_code_type code;
      vert = (k == prc_pkg::STG_LEFT || k == prc_pkg::STG_RIGHT);
      hi   = (k == prc_pkg::STG_RIGHT || k == prc_pkg::STG_BOTTOM);
      b = (k == prc_pkg::STG_LEFT) ? bnd_x_low : (k == prc_pkg::STG_RIGHT) ? bnd_x_high :
          (k == prc_pkg::STG_BOTTOM) ? bnd_y_high : bnd_y_low;
      p1 = vert ? x1 : y1;
      p2 = vert ? x2 : y2;
      code = hi ? edge_kind(-p1, -p2, -b) : edge_kind(p1, p2, b);
      if (code == prc_pkg::EDGE_OUT_IN || code == prc_pkg::EDGE_IN_OUT) begin
         if (vert) feed_stage(k + 1, b, lerp_coord(x1, y1, x2, y2, b));
         else      feed_stage(k + 1, lerp_coord(y1, x1, y2, x2, b), b);
         if (code == prc_pkg::EDGE_OUT_IN) feed_stage(k + 1, x2, y2);
      end else if (code == prc_pkg::EDGE_IN_IN) begin
         feed_stage(k + 1, x2, y2);
      end
   endfunction

   function automatic void close_polygon();
      for (int k = 0; k < 4; k++) begin
         if (stg_open[k])
            clip_edge_k(k, stg_prev_x[k], stg_prev_y[k], stg_first_x[k], stg_first_y[k]);
         stg_open[k] = 1'b0;
      end
      if (hold_valid) push_word(hold_x, hold_y, 1'b1, 1'b0);
      else            push_word(0, 0, 1'b1, 1'b1);
      hold_valid = 1'b0;
   endfunction

   // ------------------------------------------------------------ driving tasks

   // valid stays high between words sent back to back; it drops only while idling
   task automatic send_vertex(logic [CW-1:0] x, logic [CW-1:0] y, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_x    <= x;
      req_in_y    <= y;
      req_in_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // word accepted at this edge
      feed_stage(0, longint'($signed(x)), longint'($signed(y)));
      if (last) close_polygon();
   endtask

   // waits for the queue of expected words to drain, then for the block's tail
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_bound(logic [prc_pkg::CSR_IDX_W-1:0] idx, logic [CW-1:0] val);
      longint v;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      v = longint'($signed(val));
      case (idx)
         prc_pkg::REG_X_LOW:  bnd_x_low  = v;
         prc_pkg::REG_Y_LOW:  bnd_y_low  = v;
         prc_pkg::REG_X_HIGH: bnd_x_high = v;
         default:             bnd_y_high = v;
      endcase
   endtask

   task automatic set_window(int xl, int yl, int xh, int yh);
      drain();
      write_bound(prc_pkg::REG_X_LOW, xl[CW-1:0]);
      write_bound(prc_pkg::REG_Y_LOW, yl[CW-1:0]);
      write_bound(prc_pkg::REG_X_HIGH, xh[CW-1:0]);
      write_bound(prc_pkg::REG_Y_HIGH, yh[CW-1:0]);
      csr_valid <= 1'b0;
   endtask

   task automatic send_poly(int n, int span, int centre);
      for (int i = 0; i < n; i++)
         send_vertex(16'(centre + $signed($urandom_range(2 * span)) - span),
                     16'(centre + $signed($urandom_range(2 * span)) - span), i == n - 1);
   endtask

   // -------------------------------------------------------------- test tasks

   // extremes, boundary points, single vertex, fully outside, crossing edges
   task automatic test_directed();
      send_vertex(16'd300, 16'd300, 1'b1);                    // single vertex inside
      send_vertex(16'h8000, 16'h8000, 1'b1);                  // single vertex outside
      send_vertex(16'd100, 16'd300, 1'b0);                    // crossing on every side
      send_vertex(16'd300, 16'd500, 1'b0);
      send_vertex(16'd500, 16'd300, 1'b0);
      send_vertex(16'd300, 16'd100, 1'b1);
      send_vertex(16'd200, 16'd200, 1'b0);                    // corners on boundary
      send_vertex(16'd400, 16'd200, 1'b0);
      send_vertex(16'd400, 16'd400, 1'b0);
      send_vertex(16'd200, 16'd400, 1'b1);
      send_vertex(16'h8000, 16'h7fff, 1'b0);                  // full-range edges
      send_vertex(16'h7fff, 16'h8000, 1'b0);
      send_vertex(16'h7fff, 16'h7fff, 1'b1);
      send_vertex(16'hffff, 16'hffff, 1'b0);                  // wholly outside
      send_vertex(16'd0, 16'd0, 1'b0);
      send_vertex(16'd150, 16'd100, 1'b1);
      send_vertex(16'd200, 16'd300, 1'b0);                    // boundary in, out
      send_vertex(16'd100, 16'd300, 1'b0);
      send_vertex(16'd200, 16'd250, 1'b1);
   endtask

   task automatic test_random(int unsigned n_items);
      int unsigned sent;
      int n;
      sent = 0;
      while (sent < n_items) begin
         n = $urandom_range(1, 8);
         case ($urandom_range(9))
            0:       send_poly(n, 32767, 0);             // anywhere, noise
            1:       send_poly(n, 10, int'(bnd_x_low));  // hugging a boundary
            default: send_poly(n, 250, 300);
         endcase
         sent += n;
      end
   endtask

   // ----------------------------------------------------------------- checker

   always @(posedge clock) begin
      clip_word_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word x=%0h y=%0h", rsp_out_x, rsp_out_y);
               n_fail++;
            end else begin
               w = expected_words.pop_front();
               if (w.empty != rsp_out_empty) begin
                  $error("out_empty exp %0d got %0d", w.empty, rsp_out_empty);
                  n_fail++;
               end
               if (w.last != rsp_out_last) begin
                  $error("out_last exp %0d got %0d", w.last, rsp_out_last);
                  n_fail++;
               end
               if (!w.empty && w.x != rsp_out_x) begin
                  $error("out_x exp %0d got %0d", $signed(w.x), $signed(rsp_out_x));
                  n_fail++;
               end
               if (!w.empty && w.y != rsp_out_y) begin
                  $error("out_y exp %0d got %0d", $signed(w.y), $signed(rsp_out_y));
                  n_fail++;
               end
            end
         end
      end
   end

   // -------------------------------------------------------------------- main

   initial begin
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_x = '0;
      req_in_y = '0;
      req_in_last = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      bnd_x_low = prc_pkg::X_LOW_RST;
      bnd_y_low = prc_pkg::Y_LOW_RST;
      bnd_x_high = prc_pkg::X_HIGH_RST;
      bnd_y_high = prc_pkg::Y_HIGH_RST;
      hold_valid = 1'b0;
      for (int k = 0; k < 4; k++) stg_open[k] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();                 // reset window
      test_random(50);

      set_window(-100, -50, 120, 90);  // window round the origin
      send_idle_pct = 80;
      test_random(50);

      set_window(-32768, -32768, 32767, 32767);   // whole plane
      send_idle_pct = 0;
      recv_stall_pct = 80;
      test_directed();
      test_random(40);

      set_window(300, 300, 300, 300);  // degenerate point window
      send_idle_pct = 23;
      recv_stall_pct = 23;
      test_random(30);

      set_window(200, 200, 400, 400);
      test_random(30);

      drain();
      if (n_fail == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
